// ----- sv/ssa_pkg.sv -----
// Shared constants, command/status structs and multiplier select codes
// for the separation steering accumulator. No dependencies.
package ssa_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_NEIGHBORS = 1024;
    localparam int CNT_W         = 11;
    localparam int SUM_W         = 48;
    localparam int REG_W         = 31;
    localparam int PROD_W        = 64;
    localparam int REM_W         = 64;
    localparam int NUM_W         = 62 + FRAC_BITS;
    localparam int TERM_STEPS    = 31;
    localparam int AVG_STEPS     = SUM_W;
    localparam int STEP_W        = 6;

    // Configuration register indexes
    localparam logic REG_AVOID_RADIUS = 1'b0;
    localparam logic REG_STEER_GAIN   = 1'b1;

    // Multiplier operand select
    localparam logic [2:0] MUL_SQX = 3'd0;
    localparam logic [2:0] MUL_SQZ = 3'd1;
    localparam logic [2:0] MUL_RR  = 3'd2;
    localparam logic [2:0] MUL_GX  = 3'd3;
    localparam logic [2:0] MUL_GZ  = 3'd4;

    typedef struct packed {
        logic       load_in;
        logic       calc_diff;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       dsq_ld;
        logic       dsq_add;
        logic       div_load;
        logic       div_term;
        logic       div_z;
        logic       div_step;
        logic       acc_x;
        logic       acc_z;
        logic       out_x;
        logic       out_z;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic early_ok;
        logic keep;
        logic last;
        logic total_zero;
        logic out_free;
    } status_t;

endpackage

// ----- sv/separation_steering_accumulator_unit.sv -----
// Top level of the separation steering accumulator: controller plus datapath.
// Depends on ssa_pkg, ssa_ctrl and ssa_datapath.
//
// One neighbor per input transaction; the block holds in_stall high while it
// works on it. A neighbor that is the agent itself or outside the radius on
// either axis is dropped at the first check. A neighbor that fails the exact
// squared-distance check is dropped at the second. A kept neighbor uses the
// shared 32x32 multiplier and two 31-step passes of the restoring divider
// (one per axis). A last item with kept neighbors adds two 48-step
// average divisions before the result enters the output register; with no
// kept neighbor the last item goes straight to the emit step. The output
// register lets the next transaction be accepted while a result waits on out_stall.
module separation_steering_accumulator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [30:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         agent_id,
    input  logic signed [31:0]  agent_x,
    input  logic signed [31:0]  agent_z,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  vel_z,
    input  logic [15:0]         other_id,
    input  logic signed [31:0]  other_x,
    input  logic signed [31:0]  other_z,
    input  logic                last_neighbor,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         result_agent_id,
    output logic signed [31:0]  steered_vel_x,
    output logic signed [31:0]  steered_vel_y,
    output logic signed [31:0]  steered_vel_z,
    output logic [10:0]         near_count
);
    import ssa_pkg::*;

    cmd_t    cmd;
    status_t status;

    ssa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ssa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .agent_id        (agent_id),
        .agent_x         (agent_x),
        .agent_z         (agent_z),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .vel_z           (vel_z),
        .other_id        (other_id),
        .other_x         (other_x),
        .other_z         (other_z),
        .last_neighbor   (last_neighbor),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_agent_id (result_agent_id),
        .steered_vel_x   (steered_vel_x),
        .steered_vel_y   (steered_vel_y),
        .steered_vel_z   (steered_vel_z),
        .near_count      (near_count)
    );

endmodule

// ----- sv/ssa_datapath.sv -----
// Datapath: input latches, configuration registers, shared multiplier,
// restoring divider, accumulators and output register. Uses ssa_pkg.
module ssa_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssa_pkg::cmd_t        cmd,
    output ssa_pkg::status_t     status,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [30:0]          cfg_data,
    input  logic [15:0]          agent_id,
    input  logic signed [31:0]   agent_x,
    input  logic signed [31:0]   agent_z,
    input  logic signed [31:0]   vel_x,
    input  logic signed [31:0]   vel_y,
    input  logic signed [31:0]   vel_z,
    input  logic [15:0]          other_id,
    input  logic signed [31:0]   other_x,
    input  logic signed [31:0]   other_z,
    input  logic                 last_neighbor,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [15:0]          result_agent_id,
    output logic signed [31:0]   steered_vel_x,
    output logic signed [31:0]   steered_vel_y,
    output logic signed [31:0]   steered_vel_z,
    output logic [10:0]          near_count
);
    import ssa_pkg::*;

    logic [REG_W-1:0]  radius_reg, gain_reg;
    logic [15:0]       aid_reg, oid_reg;
    logic [31:0]       agx_reg, agz_reg, ox_reg, oz_reg;
    logic [31:0]       vx_reg, vy_reg, vz_reg;
    logic              last_reg;
    logic [32:0]       ax_reg, az_reg;
    logic              sx_reg, sz_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] dsq_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  dvd_reg, q_reg, den_lo_unused;
    logic [REM_W-1:0]  den_reg;
    logic              sat_reg, avg_neg_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_z_reg;
    logic [CNT_W-1:0]  total_reg;
    logic signed [31:0] stx_reg, stz_reg;
    logic              out_valid_reg;
    logic [15:0]       res_id_reg;
    logic [31:0]       res_x_reg, res_y_reg, res_z_reg;
    logic [CNT_W-1:0]  res_cnt_reg;

    logic signed [32:0] dx, dz;
    logic [31:0]        mul_a, mul_b;
    logic [NUM_W-1:0]   num;
    logic [REM_W-1:0]   trial, rem_init;
    logic [SUM_W-1:0]   term_mag, sum_mag;
    logic signed [SUM_W-1:0] term_s;
    logic signed [SUM_W:0]   avg_s;
    logic signed [SUM_W+1:0] diff_s;
    logic signed [31:0]      vel_sel, steer_sat;

    assign den_lo_unused = '0;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= REG_W'(65536);
            gain_reg   <= REG_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AVOID_RADIUS: radius_reg <= cfg_data;
                REG_STEER_GAIN:   gain_reg   <= cfg_data;
                default:          radius_reg <= radius_reg;
            endcase
        end
    end

    assign dx = $signed({ox_reg[31], ox_reg}) - $signed({agx_reg[31], agx_reg});
    assign dz = $signed({oz_reg[31], oz_reg}) - $signed({agz_reg[31], agz_reg});

    always_comb
    begin
        mul_a = ax_reg[31:0];
        mul_b = ax_reg[31:0];
        case (cmd.mul_sel)
            MUL_SQX:
            begin
                mul_a = ax_reg[31:0];
                mul_b = ax_reg[31:0];
            end
            MUL_SQZ:
            begin
                mul_a = az_reg[31:0];
                mul_b = az_reg[31:0];
            end
            MUL_RR:
            begin
                mul_a = {1'b0, radius_reg};
                mul_b = {1'b0, radius_reg};
            end
            MUL_GX:
            begin
                mul_a = {1'b0, gain_reg};
                mul_b = ax_reg[31:0];
            end
            MUL_GZ:
            begin
                mul_a = {1'b0, gain_reg};
                mul_b = az_reg[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign num      = {prod_reg[61:0], {FRAC_BITS{1'b0}}};
    assign rem_init = REM_W'(num[NUM_W-1:TERM_STEPS]);
    assign trial    = {rem_reg[REM_W-2:0], dvd_reg[SUM_W-1]};
    assign sum_mag  = cmd.div_z ? (sum_z_reg[SUM_W-1] ? SUM_W'(-sum_z_reg) : sum_z_reg)
                                : (sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : sum_x_reg);

    // Term magnitude saturates at 2^31-1
    assign term_mag = sat_reg ? SUM_W'(32'h7FFF_FFFF) : SUM_W'(q_reg[TERM_STEPS-1:0]);
    assign term_s   = (cmd.acc_z ? sz_reg : sx_reg) ? -$signed(term_mag) : $signed(term_mag);

    assign avg_s    = avg_neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign vel_sel  = cmd.out_z ? $signed(vz_reg) : $signed(vx_reg);
    assign diff_s   = (SUM_W+2)'(vel_sel) - (SUM_W+2)'(avg_s);

    always_comb
    begin
        if (diff_s > (SUM_W+2)'(64'sh7FFF_FFFF))
            steer_sat = 32'sh7FFF_FFFF;
        else if (diff_s < -(SUM_W+2)'(64'sh8000_0000))
            steer_sat = 32'sh8000_0000;
        else
            steer_sat = diff_s[31:0];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            aid_reg  <= agent_id;
            oid_reg  <= other_id;
            agx_reg  <= agent_x;
            agz_reg  <= agent_z;
            ox_reg   <= other_x;
            oz_reg   <= other_z;
            vx_reg   <= vel_x;
            vy_reg   <= vel_y;
            vz_reg   <= vel_z;
            last_reg <= last_neighbor;
        end
        if (cmd.calc_diff)
        begin
            sx_reg <= dx[32];
            sz_reg <= dz[32];
            ax_reg <= dx[32] ? 33'(-dx) : 33'(dx);
            az_reg <= dz[32] ? 33'(-dz) : 33'(dz);
        end
        if (cmd.mul_en)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.dsq_ld)
            dsq_reg <= prod_reg;
        else if (cmd.dsq_add)
            dsq_reg <= dsq_reg + prod_reg;
        if (cmd.div_load)
        begin
            q_reg <= '0;
            if (cmd.div_term)
            begin
                rem_reg <= rem_init;
                dvd_reg <= {num[TERM_STEPS-1:0], {(SUM_W-TERM_STEPS){1'b0}}};
                den_reg <= dsq_reg;
                sat_reg <= (rem_init >= dsq_reg);
            end
            else
            begin
                rem_reg     <= '0;
                dvd_reg     <= sum_mag | den_lo_unused;
                den_reg     <= REM_W'(total_reg);
                sat_reg     <= 1'b0;
                avg_neg_reg <= cmd.div_z ? sum_z_reg[SUM_W-1] : sum_x_reg[SUM_W-1];
            end
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
            if (trial >= den_reg)
            begin
                rem_reg <= trial - den_reg;
                q_reg   <= {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_x)
            stx_reg <= steer_sat;
        if (cmd.out_z)
            stz_reg <= steer_sat;
        if (cmd.emit)
        begin
            res_id_reg  <= aid_reg;
            res_x_reg   <= (total_reg == '0) ? vx_reg : stx_reg;
            res_y_reg   <= vy_reg;
            res_z_reg   <= (total_reg == '0) ? vz_reg : stz_reg;
            res_cnt_reg <= total_reg;
        end
    end

    // Accumulators and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_z_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                sum_x_reg <= '0;
                sum_z_reg <= '0;
                total_reg <= '0;
            end
            else
            begin
                if (cmd.acc_x)
                    sum_x_reg <= sum_x_reg + term_s;
                if (cmd.acc_z)
                begin
                    sum_z_reg <= sum_z_reg + term_s;
                    total_reg <= total_reg + CNT_W'(1);
                end
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.early_ok   = (aid_reg != oid_reg)
                             && (ax_reg <= {2'b00, radius_reg})
                             && (az_reg <= {2'b00, radius_reg});
    assign status.keep       = (dsq_reg != '0) && (dsq_reg <= prod_reg)
                             && (total_reg < CNT_W'(MAX_NEIGHBORS));
    assign status.last       = last_reg;
    assign status.total_zero = (total_reg == '0);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign result_agent_id = res_id_reg;
    assign steered_vel_x   = res_x_reg;
    assign steered_vel_y   = res_y_reg;
    assign steered_vel_z   = res_z_reg;
    assign near_count      = res_cnt_reg;

`ifndef NO_ASSERTIONS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_NEIGHBORS))
        else $error("neighbor count past limit");
`endif

endmodule

// ----- sv/ssa_ctrl.sv -----
// Controller: sequences one neighbor transaction through the datapath
// and the final average on the last item. Uses ssa_pkg.
module ssa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ssa_pkg::status_t  status,
    output ssa_pkg::cmd_t     cmd
);
    import ssa_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DIFF = 5'd1;
    localparam logic [4:0] S_CHK1 = 5'd2;
    localparam logic [4:0] S_SQX  = 5'd3;
    localparam logic [4:0] S_SQZ  = 5'd4;
    localparam logic [4:0] S_RR   = 5'd5;
    localparam logic [4:0] S_CHK2 = 5'd6;
    localparam logic [4:0] S_GX   = 5'd7;
    localparam logic [4:0] S_DLX  = 5'd8;
    localparam logic [4:0] S_DVX  = 5'd9;
    localparam logic [4:0] S_ACX  = 5'd10;
    localparam logic [4:0] S_GZ   = 5'd11;
    localparam logic [4:0] S_DLZ  = 5'd12;
    localparam logic [4:0] S_DVZ  = 5'd13;
    localparam logic [4:0] S_ACZ  = 5'd14;
    localparam logic [4:0] S_TAIL = 5'd15;
    localparam logic [4:0] S_AVLX = 5'd16;
    localparam logic [4:0] S_AVX  = 5'd17;
    localparam logic [4:0] S_OUTX = 5'd18;
    localparam logic [4:0] S_AVLZ = 5'd19;
    localparam logic [4:0] S_AVZ  = 5'd20;
    localparam logic [4:0] S_OUTZ = 5'd21;
    localparam logic [4:0] S_EMIT = 5'd22;

    logic [4:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = S_CHK1;
            end
            S_CHK1:
                state_next = status.early_ok ? S_SQX : S_TAIL;
            S_SQX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQX;
                state_next  = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQZ;
                cmd.dsq_ld  = 1'b1;
                state_next  = S_RR;
            end
            S_RR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RR;
                cmd.dsq_add = 1'b1;
                state_next  = S_CHK2;
            end
            S_CHK2:
                state_next = status.keep ? S_GX : S_TAIL;
            S_GX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GX;
                state_next  = S_DLX;
            end
            S_DLX:
            begin
                cmd.div_load = 1'b1;
                cmd.div_term = 1'b1;
                step_next    = STEP_W'(TERM_STEPS - 1);
                state_next   = S_DVX;
            end
            S_DVX:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - STEP_W'(1);
                if (step_reg == '0)
                    state_next = S_ACX;
            end
            S_ACX:
            begin
                cmd.acc_x  = 1'b1;
                state_next = S_GZ;
            end
            S_GZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GZ;
                state_next  = S_DLZ;
            end
            S_DLZ:
            begin
                cmd.div_load = 1'b1;
                cmd.div_term = 1'b1;
                step_next    = STEP_W'(TERM_STEPS - 1);
                state_next   = S_DVZ;
            end
            S_DVZ:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - STEP_W'(1);
                if (step_reg == '0)
                    state_next = S_ACZ;
            end
            S_ACZ:
            begin
                cmd.acc_z  = 1'b1;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                if (!status.last)
                    state_next = S_IDLE;
                else if (status.total_zero)
                    state_next = S_EMIT;
                else
                    state_next = S_AVLX;
            end
            S_AVLX:
            begin
                cmd.div_load = 1'b1;
                step_next    = STEP_W'(AVG_STEPS - 1);
                state_next   = S_AVX;
            end
            S_AVX:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - STEP_W'(1);
                if (step_reg == '0)
                    state_next = S_OUTX;
            end
            S_OUTX:
            begin
                cmd.out_x  = 1'b1;
                state_next = S_AVLZ;
            end
            S_AVLZ:
            begin
                cmd.div_load = 1'b1;
                cmd.div_z    = 1'b1;
                step_next    = STEP_W'(AVG_STEPS - 1);
                state_next   = S_AVZ;
            end
            S_AVZ:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - STEP_W'(1);
                if (step_reg == '0)
                    state_next = S_OUTZ;
            end
            S_OUTZ:
            begin
                cmd.out_z  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_diff: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DIFF)
        else $error("accepted transaction not started");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DVX && step_reg == '0 |=> state_reg == S_ACX)
        else $error("divider step count overrun");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted into a full output register");
`endif

endmodule
